FILE: hdl/gaussian_3d_weight_fast_exp_core_macros.svh
// ---------------------------------------------------------------------------
// gaussian_3d_weight_fast_exp_core_macros
// assertion macros used by the checker file of the gaussian weight core
// ---------------------------------------------------------------------------
`ifndef GAUSSIAN_3D_WEIGHT_FAST_EXP_CORE_MACROS_SVH
`define GAUSSIAN_3D_WEIGHT_FAST_EXP_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define G3DW_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define G3DW_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/g3dw_pkg.sv
// ---------------------------------------------------------------------------
// g3dw_pkg
// types and fixed-point constants of the gaussian weight core
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package g3dw_pkg;

  localparam int FRAC_W      = 24;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int IV_W        = 32;
  localparam int S_W         = 32;
  localparam int LATENCY     = 13;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CENTER_X        = 3'd0,
    CFG_CENTER_Y        = 3'd1,
    CFG_CENTER_Z        = 3'd2,
    CFG_INV_VAR_LATERAL = 3'd3,
    CFG_INV_VAR_AXIAL   = 3'd4
  } cfg_reg_t;

  localparam logic [IV_W-1:0] IV_RESET  = 32'h0100_0000;
  localparam logic [S_W-1:0]  S_CAP     = 32'h8000_0000;
  localparam logic [S_W-1:0]  T_CAP     = 32'h4000_0000;
  localparam logic [30:0]     LOG2E_Q30 = 31'd1549082005;
  localparam logic [22:0]     C2_Q24    = 23'd5657100;
  localparam logic [23:0]     C1_Q24    = 24'd11033306;
  localparam logic [24:0]     C0_Q24    = 25'd16806153;

  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

endpackage

FILE: hdl/g3dw_dist.sv
// ---------------------------------------------------------------------------
// g3dw_dist
// offsets from the centre, squares and lateral sum over three stages
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module g3dw_dist import g3dw_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  stage_ctl_t                    ctl_i,
  input  logic signed [COORD_WIDTH-1:0] pos_x,
  input  logic signed [COORD_WIDTH-1:0] pos_y,
  input  logic signed [COORD_WIDTH-1:0] pos_z,
  input  logic        [COORD_WIDTH-1:0] center_x,
  input  logic        [COORD_WIDTH-1:0] center_y,
  input  logic        [COORD_WIDTH-1:0] center_z,
  output stage_ctl_t                    ctl_o,
  output logic [2*(COORD_WIDTH+1):0]    lat_o,
  output logic [2*(COORD_WIDTH+1)-1:0]  ax_o
);

  localparam int MAG_W = COORD_WIDTH + 1;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int LAT_W = SQ_W + 1;
  localparam int NSTG  = 3;

  stage_ctl_t       ctl_r [NSTG];
  logic [MAG_W-1:0] dx_nxt, dy_nxt, dz_nxt;
  logic [MAG_W-1:0] mag_x_nxt, mag_y_nxt, mag_z_nxt;
  logic [MAG_W-1:0] mag_x_r, mag_y_r, mag_z_r;
  logic [SQ_W-1:0]  sq_x_nxt, sq_y_nxt, sq_z_nxt;
  logic [SQ_W-1:0]  sq_x_r, sq_y_r, sq_z_r;
  logic [LAT_W-1:0] lat_nxt, lat_r;
  logic [SQ_W-1:0]  ax_r;

  // signed offsets, one bit wider than the coordinates
  assign dx_nxt = {pos_x[COORD_WIDTH-1], pos_x} - {center_x[COORD_WIDTH-1], center_x};
  assign dy_nxt = {pos_y[COORD_WIDTH-1], pos_y} - {center_y[COORD_WIDTH-1], center_y};
  assign dz_nxt = {pos_z[COORD_WIDTH-1], pos_z} - {center_z[COORD_WIDTH-1], center_z};

  assign mag_x_nxt = dx_nxt[MAG_W-1] ? (~dx_nxt + 1'b1) : dx_nxt;
  assign mag_y_nxt = dy_nxt[MAG_W-1] ? (~dy_nxt + 1'b1) : dy_nxt;
  assign mag_z_nxt = dz_nxt[MAG_W-1] ? (~dz_nxt + 1'b1) : dz_nxt;

  assign sq_x_nxt = mag_x_r * mag_x_r;
  assign sq_y_nxt = mag_y_r * mag_y_r;
  assign sq_z_nxt = mag_z_r * mag_z_r;

  assign lat_nxt = LAT_W'(sq_x_r) + LAT_W'(sq_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTG; i++) begin
        ctl_r[i] <= '0;
      end
    end else begin
      ctl_r[0] <= ctl_i;
      for (int i = 1; i < NSTG; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_x_r <= mag_x_nxt;
    mag_y_r <= mag_y_nxt;
    mag_z_r <= mag_z_nxt;
    sq_x_r  <= sq_x_nxt;
    sq_y_r  <= sq_y_nxt;
    sq_z_r  <= sq_z_nxt;
    lat_r   <= lat_nxt;
    ax_r    <= sq_z_r;
  end

  assign ctl_o = ctl_r[NSTG-1];
  assign lat_o = lat_r;
  assign ax_o  = ax_r;

endmodule

FILE: hdl/g3dw_scale.sv
// ---------------------------------------------------------------------------
// g3dw_scale
// scaling by the reciprocal variances and saturated sum over three stages
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module g3dw_scale import g3dw_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  stage_ctl_t                   ctl_i,
  input  logic [2*(COORD_WIDTH+1):0]   lat_i,
  input  logic [2*(COORD_WIDTH+1)-1:0] ax_i,
  input  logic [IV_W-1:0]              iv_lat,
  input  logic [IV_W-1:0]              iv_ax,
  output stage_ctl_t                   ctl_o,
  output logic [S_W-1:0]               s_o
);

  localparam int SQ_W   = 2 * (COORD_WIDTH + 1);
  localparam int LAT_W  = SQ_W + 1;
  localparam int LO_W   = 16;
  localparam int BIG_LO = 47;
  localparam int XW     = (LAT_W > BIG_LO + 1) ? LAT_W : BIG_LO + 1;
  localparam int HI_W   = BIG_LO - LO_W;
  localparam int PH_W   = HI_W + IV_W;
  localparam int PL_W   = LO_W + IV_W;
  localparam int SUM_W  = 64;
  localparam int NSTG   = 3;

  stage_ctl_t        ctl_r [NSTG];
  logic [XW-1:0]     lat_x, ax_x;
  logic              cap_l_nxt, cap_a_nxt, cap_l_r, cap_a_r;
  logic [PH_W-1:0]   ph_l_nxt, ph_a_nxt, ph_l_r, ph_a_r;
  logic [PL_W-1:0]   pl_l_nxt, pl_a_nxt, pl_l_r, pl_a_r;
  logic [SUM_W-1:0]  sum_l, sum_a;
  logic [S_W-1:0]    term_l_nxt, term_a_nxt, term_l_r, term_a_r;
  logic [S_W:0]      s_sum;
  logic [S_W-1:0]    s_nxt, s_r;

  assign lat_x = XW'(lat_i);
  assign ax_x  = XW'(ax_i);

  // a square of 2^47 or more saturates any non-zero term
  assign cap_l_nxt = (|lat_x[XW-1:BIG_LO]) && (iv_lat != '0);
  assign cap_a_nxt = (|ax_x[XW-1:BIG_LO]) && (iv_ax != '0);
  assign ph_l_nxt  = lat_x[BIG_LO-1:LO_W] * iv_lat;
  assign ph_a_nxt  = ax_x[BIG_LO-1:LO_W] * iv_ax;
  assign pl_l_nxt  = lat_x[LO_W-1:0] * iv_lat;
  assign pl_a_nxt  = ax_x[LO_W-1:0] * iv_ax;

  assign sum_l = SUM_W'(ph_l_r) + SUM_W'(pl_l_r[PL_W-1:LO_W]);
  assign sum_a = SUM_W'(ph_a_r) + SUM_W'(pl_a_r[PL_W-1:LO_W]);
  assign term_l_nxt = (cap_l_r || (sum_l[SUM_W-1:S_W-1] != '0)) ? S_CAP : sum_l[S_W-1:0];
  assign term_a_nxt = (cap_a_r || (sum_a[SUM_W-1:S_W-1] != '0)) ? S_CAP : sum_a[S_W-1:0];

  assign s_sum = (S_W+1)'(term_l_r) + (S_W+1)'(term_a_r);
  assign s_nxt = (s_sum[S_W:S_W-1] != '0) ? S_CAP : s_sum[S_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTG; i++) begin
        ctl_r[i] <= '0;
      end
    end else begin
      ctl_r[0] <= ctl_i;
      for (int i = 1; i < NSTG; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    cap_l_r  <= cap_l_nxt;
    cap_a_r  <= cap_a_nxt;
    ph_l_r   <= ph_l_nxt;
    ph_a_r   <= ph_a_nxt;
    pl_l_r   <= pl_l_nxt;
    pl_a_r   <= pl_a_nxt;
    term_l_r <= term_l_nxt;
    term_a_r <= term_a_nxt;
    s_r      <= s_nxt;
  end

  assign ctl_o = ctl_r[NSTG-1];
  assign s_o   = s_r;

endmodule

FILE: hdl/g3dw_exp.sv
// ---------------------------------------------------------------------------
// g3dw_exp
// fast base-2 exponential: log2(e) scaling, split, quadratic and round shift
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module g3dw_exp import g3dw_pkg::*; #(
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  stage_ctl_t             ctl_i,
  input  logic [S_W-1:0]         s_i,
  output stage_ctl_t             ctl_o,
  output logic [OUT_FRAC_BITS:0] weight_o
);

  localparam int W_W    = OUT_FRAC_BITS + 1;
  localparam int SH0    = FRAC_W - OUT_FRAC_BITS;
  localparam int KMAX   = 25 - SH0;
  localparam int K_W    = 7;
  localparam int SHF_W  = 5;
  localparam int PROD_W = S_W + 31;
  localparam int M1_W   = 23 + FRAC_W;
  localparam int M2_W   = 2 * FRAC_W;
  localparam int P_W    = FRAC_W + 1;
  localparam int NSTG   = 7;

  stage_ctl_t         ctl_r [NSTG];
  logic [PROD_W-1:0]  prod_nxt, prod_r;
  logic [S_W-1:0]     t_raw, t_cap;
  logic [FRAC_W-1:0]  r_frac;
  logic [K_W-1:0]     k_nxt, k2_r;
  logic [FRAC_W-1:0]  f_nxt, f2_r, f3_r, f4_r;
  logic [M1_W-1:0]    m1_nxt, m1_r;
  logic               zero_nxt, zero3_r, zero4_r, zero5_r, zero6_r;
  logic [SHF_W-1:0]   shamt_nxt, shamt3_r, shamt4_r, shamt5_r, shamt6_r;
  logic [FRAC_W-1:0]  b_nxt, b_r;
  logic [M2_W-1:0]    m2_nxt, m2_r;
  logic [P_W-1:0]     p_nxt, p_r;
  logic [P_W-1:0]     q;
  logic [P_W:0]       q_inc;
  logic [W_W-1:0]     weight_nxt, weight_r;

  // t = s * log2(e) / 2, saturated at 64.0
  assign prod_nxt = s_i * LOG2E_Q30;
  assign t_raw    = prod_r[PROD_W-1:31];
  assign t_cap    = (t_raw > T_CAP) ? T_CAP : t_raw;
  assign r_frac   = t_cap[FRAC_W-1:0];
  assign k_nxt    = t_cap[FRAC_W+K_W-1:FRAC_W] + K_W'(r_frac != '0);
  // one minus the fraction, zero when the fraction is zero
  assign f_nxt    = ~r_frac + 1'b1;

  assign zero_nxt  = (k2_r > K_W'(KMAX));
  assign shamt_nxt = SHF_W'(SH0 - 1) + k2_r[SHF_W-1:0];
  assign m1_nxt    = C2_Q24 * f2_r;

  assign b_nxt  = FRAC_W'(m1_r[M1_W-1:FRAC_W]) + C1_Q24;
  assign m2_nxt = b_r * f4_r;
  assign p_nxt  = P_W'(m2_r[M2_W-1:FRAC_W]) + C0_Q24;

  // round half up: shift by one less, add one, drop the last bit
  assign q          = p_r >> shamt6_r;
  assign q_inc      = (P_W+1)'(q) + 1'b1;
  assign weight_nxt = zero6_r ? '0 : q_inc[W_W:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTG; i++) begin
        ctl_r[i] <= '0;
      end
    end else begin
      ctl_r[0] <= ctl_i;
      for (int i = 1; i < NSTG; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r   <= prod_nxt;
    k2_r     <= k_nxt;
    f2_r     <= f_nxt;
    m1_r     <= m1_nxt;
    f3_r     <= f2_r;
    zero3_r  <= zero_nxt;
    shamt3_r <= shamt_nxt;
    b_r      <= b_nxt;
    f4_r     <= f3_r;
    zero4_r  <= zero3_r;
    shamt4_r <= shamt3_r;
    m2_r     <= m2_nxt;
    zero5_r  <= zero4_r;
    shamt5_r <= shamt4_r;
    p_r      <= p_nxt;
    zero6_r  <= zero5_r;
    shamt6_r <= shamt5_r;
    weight_r <= weight_nxt;
  end

  assign ctl_o    = ctl_r[NSTG-1];
  assign weight_o = weight_r;

endmodule

FILE: hdl/gaussian_3d_weight_fast_exp_core.sv
// ---------------------------------------------------------------------------
// gaussian_3d_weight_fast_exp_core
// anisotropic 3-d gaussian weight with a fast base-2 exponential
// ---------------------------------------------------------------------------
// Takes one point word on every clock cycle and returns its weight with
// out_strobe high for a single cycle. The pipeline has three stages for the
// offsets and squares, three for the variance scaling and saturated sum and
// seven for the exponential (two of them for the quadratic's multipliers).
// busy stays low, and the receiver has to take every word as it appears.
// The user writes centre and reciprocal variances through the cfg_ port only
// while no point is in flight; the block does not enforce it. The weight is
// unsigned Q1.OUT_FRAC_BITS.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gaussian_3d_weight_fast_exp_core import g3dw_pkg::*; #(
  parameter int COORD_WIDTH   = 24,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_pos_z,
  input  logic                          in_last,
  output logic                          out_strobe,
  output logic [OUT_FRAC_BITS:0]        out_weight,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  localparam int SQ_W  = 2 * (COORD_WIDTH + 1);
  localparam int LAT_W = SQ_W + 1;

  logic [COORD_WIDTH-1:0] center_x_r, center_y_r, center_z_r;
  logic [IV_W-1:0]        inv_var_lateral_r, inv_var_axial_r;
  stage_ctl_t             in_ctl, dist_ctl, scale_ctl, exp_ctl;
  logic [LAT_W-1:0]       lat;
  logic [SQ_W-1:0]        ax;
  logic [S_W-1:0]         s_val;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r        <= '0;
      center_y_r        <= '0;
      center_z_r        <= '0;
      inv_var_lateral_r <= IV_RESET;
      inv_var_axial_r   <= IV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTER_X:        center_x_r        <= cfg_wdata[COORD_WIDTH-1:0];
        CFG_CENTER_Y:        center_y_r        <= cfg_wdata[COORD_WIDTH-1:0];
        CFG_CENTER_Z:        center_z_r        <= cfg_wdata[COORD_WIDTH-1:0];
        CFG_INV_VAR_LATERAL: inv_var_lateral_r <= cfg_wdata[IV_W-1:0];
        CFG_INV_VAR_AXIAL:   inv_var_axial_r   <= cfg_wdata[IV_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy         = 1'b0;
  assign in_ctl.valid = start && !busy;
  assign in_ctl.last  = in_last;

  g3dw_dist #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (in_ctl),
    .pos_x    (in_pos_x),
    .pos_y    (in_pos_y),
    .pos_z    (in_pos_z),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .center_z (center_z_r),
    .ctl_o    (dist_ctl),
    .lat_o    (lat),
    .ax_o     (ax)
  );

  g3dw_scale #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (dist_ctl),
    .lat_i  (lat),
    .ax_i   (ax),
    .iv_lat (inv_var_lateral_r),
    .iv_ax  (inv_var_axial_r),
    .ctl_o  (scale_ctl),
    .s_o    (s_val)
  );

  g3dw_exp #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_exp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (scale_ctl),
    .s_i      (s_val),
    .ctl_o    (exp_ctl),
    .weight_o (out_weight)
  );

  assign out_strobe = exp_ctl.valid;
  assign out_last   = exp_ctl.last;

endmodule

FILE: hdl/g3dw_checker.sv
// ---------------------------------------------------------------------------
// g3dw_checker
// port-level checks of the gaussian weight core, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gaussian_3d_weight_fast_exp_core_macros.svh"

module g3dw_checker import g3dw_pkg::*; #(
  parameter int COORD_WIDTH   = 24,
  parameter int OUT_FRAC_BITS = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic signed [COORD_WIDTH-1:0] in_pos_x,
  input logic                          in_last,
  input logic                          out_strobe,
  input logic [OUT_FRAC_BITS:0]        out_weight,
  input logic                          out_last
);

  localparam int W_W   = OUT_FRAC_BITS + 1;
  localparam int SH0   = FRAC_W - OUT_FRAC_BITS;
  localparam int W_MAX = ((int'(C0_Q24) >> (SH0 - 1)) + 1) >> 1;
  localparam int CNT_W = $clog2(LATENCY + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             warm;
  logic             acc;

  // cycles since reset, saturating at the pipeline depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cnt_r != CNT_W'(LATENCY)) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign warm = (cnt_r == CNT_W'(LATENCY));
  assign acc  = start && !busy;

  `G3DW_ASSERT_IMP(a_strobe_latency, clk, rst_n, warm, out_strobe == $past(acc, LATENCY), "result word not at fixed latency after its point")

  `G3DW_ASSERT_IMP(a_last_follows, clk, rst_n, warm && out_strobe, out_last == $past(in_last, LATENCY), "last flag does not follow its point")

  `G3DW_ASSERT_IMP(a_weight_bound, clk, rst_n, out_strobe, out_weight <= W_W'(W_MAX), "weight above the centre value")

  `G3DW_ASSERT_NXT(a_no_busy, clk, rst_n, acc && ($past(in_pos_x) != in_pos_x || 1'b1), !busy, "core refused a word after an accepted point")

endmodule

bind gaussian_3d_weight_fast_exp_core g3dw_checker #(
  .COORD_WIDTH   (COORD_WIDTH),
  .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_g3dw_checker (.*);
